@@ hw/rtl/rbc_pkg.sv @@
// Shared types and codes for the retry backoff controller.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package rbc_pkg;

	localparam int DelayW = 20;
	localparam int AttW   = 8;
	localparam int BaseW  = 16;
	localparam int MultW  = 8;
	localparam int RawW   = 32;
	localparam int CfgW   = 20;

	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_OUTCOME = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;
	localparam logic [1:0] OP_CANCEL  = 2'd3;

	localparam logic [2:0] EV_LAUNCH     = 3'd0;
	localparam logic [2:0] EV_SUCCEEDED  = 3'd1;
	localparam logic [2:0] EV_RETRYING   = 3'd2;
	localparam logic [2:0] EV_ALL_FAILED = 3'd3;
	localparam logic [2:0] EV_TIMED_OUT  = 3'd4;

	localparam logic [1:0] REG_ATTEMPT_LIMIT = 2'd0;
	localparam logic [1:0] REG_BASE_DELAY    = 2'd1;
	localparam logic [1:0] REG_MULTIPLIER    = 2'd2;
	localparam logic [1:0] REG_DELAY_CAP     = 2'd3;

	localparam logic [AttW-1:0]   RST_ATTEMPT_LIMIT = 8'd3;
	localparam logic [BaseW-1:0]  RST_BASE_DELAY    = 16'd1000;
	localparam logic [MultW-1:0]  RST_MULTIPLIER    = 8'd32;
	localparam logic [DelayW-1:0] RST_DELAY_CAP     = 20'd30000;

	typedef struct packed {
		logic [AttW-1:0]   attempt_limit;
		logic [BaseW-1:0]  base_delay;
		logic [MultW-1:0]  backoff_multiplier;
		logic [DelayW-1:0] delay_cap;
	} cfg_t;

	typedef struct packed {
		logic [2:0]        event_res;
		logic [AttW-1:0]   attempt_number;
		logic [DelayW-1:0] delay_value;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

@@ hw/rtl/retry_backoff_controller.sv @@
// Retry sequencer with capped exponential backoff.
// Input channel (in_valid/in_ready) carries one operation beat: start, attempt
// outcome, tick or cancel. Output channel (out_valid/out_ready) carries one
// event beat; an input beat causes zero, one or two events, the final one
// flagged by last.
// Flow: an accepted beat is registered in the input stage and processed once the
// queue has room, which writes its events into the queue; a timeout beat puts two
// events in the queue at once.
// Throughput: one input beat per cycle while the four-entry result queue holds
// at most two events; the input stalls when the output side is stalled and the
// queue fills.
// Configuration: cfg_write with cfg_index and cfg_data updates one register;
// write only while idle.
// Reset: arst_n clears the sequencer to idle, empties the queue and loads the
// register defaults (limit 3, base 1000, factor 2.0, cap 30000).
// Depends on rbc_pkg, rbc_core, rbc_delay and rbc_outq.
`default_nettype none

module retry_backoff_controller (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_write,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [rbc_pkg::CfgW-1:0]    cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  operation,
	input  wire                              success,
	input  wire logic [rbc_pkg::DelayW-1:0]  timeout_ticks,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [2:0]                       event_res,
	output logic [rbc_pkg::AttW-1:0]         attempt_number,
	output logic [rbc_pkg::DelayW-1:0]       delay_value,
	output logic                             last
);

	rbc_pkg::cfg_t    cfg_q;
	rbc_pkg::push_t   push;
	rbc_pkg::result_t head;
	logic             room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attempt_limit      <= rbc_pkg::RST_ATTEMPT_LIMIT;
			cfg_q.base_delay         <= rbc_pkg::RST_BASE_DELAY;
			cfg_q.backoff_multiplier <= rbc_pkg::RST_MULTIPLIER;
			cfg_q.delay_cap          <= rbc_pkg::RST_DELAY_CAP;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rbc_pkg::REG_ATTEMPT_LIMIT:
					cfg_q.attempt_limit <= cfg_data[rbc_pkg::AttW-1:0];
				rbc_pkg::REG_BASE_DELAY:
					cfg_q.base_delay <= cfg_data[rbc_pkg::BaseW-1:0];
				rbc_pkg::REG_MULTIPLIER:
					cfg_q.backoff_multiplier <= cfg_data[rbc_pkg::MultW-1:0];
				rbc_pkg::REG_DELAY_CAP:
					cfg_q.delay_cap <= cfg_data[rbc_pkg::DelayW-1:0];
				default: begin
				end
			endcase
		end
	end

	rbc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.success       (success),
		.timeout_ticks (timeout_ticks),
		.room          (room),
		.push          (push)
	);

	rbc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign event_res      = head.event_res;
	assign attempt_number = head.attempt_number;
	assign delay_value    = head.delay_value;
	assign last           = head.last;

endmodule

`default_nettype wire

@@ hw/rtl/rbc_delay.sv @@
// Backoff delay step: running product with saturation, then the cap.
// Attempts up to 1 start from the base delay. Depends on rbc_pkg.
`default_nettype none

module rbc_delay (
	input  wire rbc_pkg::cfg_t                 cfg,
	input  wire logic [rbc_pkg::AttW-1:0]   attempt,
	input  wire logic [rbc_pkg::RawW-1:0]   raw,
	output logic      [rbc_pkg::RawW-1:0]   raw_next,
	output logic      [rbc_pkg::DelayW-1:0] delay
);

	localparam int ProdW = rbc_pkg::RawW + rbc_pkg::MultW;

	logic [ProdW-1:0]   prod;
	logic [ProdW-5:0]   scaled;
	logic [rbc_pkg::RawW-1:0] grown;

	always_comb begin
		prod   = {{rbc_pkg::MultW{1'b0}}, raw} * {{rbc_pkg::RawW{1'b0}}, cfg.backoff_multiplier};
		scaled = prod[ProdW-1:4];
		grown  = (|scaled[ProdW-5:rbc_pkg::RawW]) ? '1 : scaled[rbc_pkg::RawW-1:0];
		if (attempt <= rbc_pkg::AttW'(1)) begin
			raw_next = {{(rbc_pkg::RawW-rbc_pkg::BaseW){1'b0}}, cfg.base_delay};
		end else begin
			raw_next = grown;
		end
		if (raw_next > {{(rbc_pkg::RawW-rbc_pkg::DelayW){1'b0}}, cfg.delay_cap}) begin
			delay = cfg.delay_cap;
		end else begin
			delay = raw_next[rbc_pkg::DelayW-1:0];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rbc_outq.sv @@
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on rbc_pkg.
`default_nettype none

module rbc_outq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire rbc_pkg::push_t  push,
	output logic                 room,
	output logic                 out_valid,
	input  wire                  out_ready,
	output rbc_pkg::result_t     head
);

	rbc_pkg::result_t mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] wr_p1;

	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= 3'd2);
	assign head      = mem_q[rd_q];
	assign wr_p1     = wr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push.cnt;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push.cnt} - {2'b0, pop};
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/rbc_core.sv @@
// Input register and sequencing state of the retry controller.
// Depends on rbc_pkg and rbc_delay.
`default_nettype none

module rbc_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire rbc_pkg::cfg_t               cfg,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  operation,
	input  wire                              success,
	input  wire logic [rbc_pkg::DelayW-1:0]  timeout_ticks,
	input  wire                              room,
	output rbc_pkg::push_t                   push
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FLIGHT = 2'd1;
	localparam logic [1:0] PH_WAIT   = 2'd2;

	logic                          valid_s1;
	logic [1:0]                    op_s1;
	logic                          success_s1;
	logic [rbc_pkg::DelayW-1:0]    tmo_s1;

	logic [1:0]                    phase_q,   phase_d;
	logic [rbc_pkg::AttW-1:0]      attempt_q, attempt_d;
	logic [rbc_pkg::RawW-1:0]      raw_q,     raw_d;
	logic [rbc_pkg::DelayW-1:0]    wait_q,    wait_d;
	logic [rbc_pkg::DelayW-1:0]    flight_q,  flight_d;
	logic [rbc_pkg::DelayW-1:0]    armed_q,   armed_d;

	logic [rbc_pkg::RawW-1:0]      raw_next;
	logic [rbc_pkg::DelayW-1:0]    delay;
	logic [rbc_pkg::DelayW-1:0]    flight_inc;
	logic [rbc_pkg::AttW-1:0]      attempt_inc;
	logic                          proc;
	logic                          fail_all;
	rbc_pkg::result_t              fail_res;
	logic [1:0]                    f_phase;
	logic [rbc_pkg::AttW-1:0]      f_attempt;
	logic [rbc_pkg::RawW-1:0]      f_raw;
	logic [rbc_pkg::DelayW-1:0]    f_wait;

	rbc_delay u_delay (
		.cfg      (cfg),
		.attempt  (attempt_q),
		.raw      (raw_q),
		.raw_next (raw_next),
		.delay    (delay)
	);

	assign proc     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= operation;
			success_s1 <= success;
			tmo_s1     <= timeout_ticks;
		end
	end

	always_comb begin
		flight_inc  = flight_q + rbc_pkg::DelayW'(1);
		attempt_inc = attempt_q + rbc_pkg::AttW'(1);
		fail_all    = (attempt_q >= cfg.attempt_limit);

		fail_res.event_res      = fail_all ? rbc_pkg::EV_ALL_FAILED : rbc_pkg::EV_RETRYING;
		fail_res.attempt_number = attempt_q;
		fail_res.delay_value    = fail_all ? '0 : delay;
		fail_res.last           = 1'b1;

		f_phase   = fail_all ? PH_IDLE : PH_WAIT;
		f_attempt = fail_all ? '0 : attempt_q;
		f_raw     = fail_all ? '0 : raw_next;
		f_wait    = fail_all ? '0 : delay;

		phase_d   = phase_q;
		attempt_d = attempt_q;
		raw_d     = raw_q;
		wait_d    = wait_q;
		flight_d  = flight_q;
		armed_d   = armed_q;
		push      = '0;

		if (proc) begin
			unique case (op_s1)
				rbc_pkg::OP_START: begin
					phase_d   = PH_FLIGHT;
					attempt_d = rbc_pkg::AttW'(1);
					raw_d     = '0;
					wait_d    = '0;
					flight_d  = '0;
					armed_d   = tmo_s1;
					push.cnt  = 2'd1;
					push.r0.event_res      = rbc_pkg::EV_LAUNCH;
					push.r0.attempt_number = rbc_pkg::AttW'(1);
					push.r0.last           = 1'b1;
				end
				rbc_pkg::OP_OUTCOME: begin
					if (phase_q == PH_FLIGHT) begin
						push.cnt = 2'd1;
						flight_d = '0;
						if (success_s1) begin
							phase_d   = PH_IDLE;
							attempt_d = '0;
							raw_d     = '0;
							wait_d    = '0;
							push.r0.event_res      = rbc_pkg::EV_SUCCEEDED;
							push.r0.attempt_number = attempt_q;
							push.r0.last           = 1'b1;
						end else begin
							phase_d   = f_phase;
							attempt_d = f_attempt;
							raw_d     = f_raw;
							wait_d    = f_wait;
							push.r0   = fail_res;
						end
					end
				end
				rbc_pkg::OP_TICK: begin
					if (phase_q == PH_FLIGHT) begin
						if (armed_q != '0) begin
							if (flight_inc >= armed_q) begin
								phase_d   = f_phase;
								attempt_d = f_attempt;
								raw_d     = f_raw;
								wait_d    = f_wait;
								flight_d  = '0;
								push.cnt  = 2'd2;
								push.r0.event_res      = rbc_pkg::EV_TIMED_OUT;
								push.r0.attempt_number = attempt_q;
								push.r0.delay_value    = armed_q;
								push.r0.last           = 1'b0;
								push.r1   = fail_res;
							end else begin
								flight_d = flight_inc;
							end
						end
					end else if (phase_q == PH_WAIT) begin
						if (wait_q <= rbc_pkg::DelayW'(1)) begin
							phase_d   = PH_FLIGHT;
							attempt_d = attempt_inc;
							wait_d    = '0;
							flight_d  = '0;
							push.cnt  = 2'd1;
							push.r0.event_res      = rbc_pkg::EV_LAUNCH;
							push.r0.attempt_number = attempt_inc;
							push.r0.last           = 1'b1;
						end else begin
							wait_d = wait_q - rbc_pkg::DelayW'(1);
						end
					end
				end
				rbc_pkg::OP_CANCEL: begin
					phase_d   = PH_IDLE;
					attempt_d = '0;
					raw_d     = '0;
					wait_d    = '0;
					flight_d  = '0;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			phase_q   <= PH_IDLE;
			attempt_q <= '0;
			raw_q     <= '0;
			wait_q    <= '0;
			flight_q  <= '0;
			armed_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			phase_q   <= phase_d;
			attempt_q <= attempt_d;
			raw_q     <= raw_d;
			wait_q    <= wait_d;
			flight_q  <= flight_d;
			armed_q   <= armed_d;
		end
	end

endmodule

`default_nettype wire

@@ dv/tb_retry_backoff_controller.sv @@
// Self-checking testbench for retry_backoff_controller: a queue-fed driver, a monitor, and a
// per-beat predictor of the backoff sequencer checked against every event beat.
// Depends on rbc_pkg and the retry_backoff_controller RTL.
`default_nettype none

module tb_retry_backoff_controller;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ProdW        = rbc_pkg::RawW + rbc_pkg::MultW;
	localparam int          SettleCycles = 8;
	localparam int unsigned CycleLimit   = 200000;

	typedef struct packed {
		logic [1:0]                 op;
		logic                       ok;
		logic [rbc_pkg::DelayW-1:0] tmo;
	} beat_t;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_FLIGHT, SEQ_WAIT} seq_phase_t;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       cfg_write      = 1'b0;
	logic [1:0]                 cfg_index      = rbc_pkg::REG_ATTEMPT_LIMIT;
	logic [rbc_pkg::CfgW-1:0]   cfg_data       = '0;
	logic                       in_valid       = 1'b0;
	logic                       in_ready;
	logic [1:0]                 operation      = rbc_pkg::OP_TICK;
	logic                       success        = 1'b0;
	logic [rbc_pkg::DelayW-1:0] timeout_ticks  = '0;
	logic                       out_valid;
	logic                       out_ready      = 1'b0;
	logic [2:0]                 event_res;
	logic [rbc_pkg::AttW-1:0]   attempt_number;
	logic [rbc_pkg::DelayW-1:0] delay_value;
	logic                       last;

	beat_t            beats_to_send[$];
	rbc_pkg::result_t events_due[$];
	rbc_pkg::result_t staged[$];
	int unsigned      tx_idle_pct  = 0;
	int unsigned      rx_stall_pct = 0;
	logic             rx_hold_req  = 1'b0;
	int unsigned      rx_hold_left = 0;
	int unsigned      cycles       = 0;
	int unsigned      errors       = 0;

	rbc_pkg::cfg_t shadow_cfg = '{attempt_limit: rbc_pkg::RST_ATTEMPT_LIMIT,
		base_delay: rbc_pkg::RST_BASE_DELAY,
		backoff_multiplier: rbc_pkg::RST_MULTIPLIER,
		delay_cap: rbc_pkg::RST_DELAY_CAP};
	seq_phase_t                 seq_phase   = SEQ_IDLE;
	logic [rbc_pkg::AttW-1:0]   seq_attempt = '0;
	logic [rbc_pkg::RawW-1:0]   seq_raw     = '0;
	logic [rbc_pkg::DelayW-1:0] seq_wait    = '0;
	logic [rbc_pkg::DelayW-1:0] seq_flight  = '0;
	logic [rbc_pkg::DelayW-1:0] seq_timeout = '0;

	retry_backoff_controller dut (.*);

	always #5 clk = ~clk;

	task automatic log_event(input logic [2:0] ev, input logic [rbc_pkg::AttW-1:0] att,
			input logic [rbc_pkg::DelayW-1:0] dly);
		rbc_pkg::result_t r;
		r.event_res      = ev;
		r.attempt_number = att;
		r.delay_value    = dly;
		r.last           = 1'b0;
		staged.push_back(r);
	endtask

	task automatic clear_sequence();
		seq_phase   = SEQ_IDLE;
		seq_attempt = '0;
		seq_raw     = '0;
		seq_wait    = '0;
		seq_flight  = '0;
	endtask

	task automatic note_failure();
		logic [ProdW-1:0]         prod;
		logic [rbc_pkg::RawW-1:0] d;
		if (seq_attempt >= shadow_cfg.attempt_limit) begin
			log_event(rbc_pkg::EV_ALL_FAILED, seq_attempt, '0);
			clear_sequence();
		end else begin
			if (seq_attempt <= 8'd1) begin
				seq_raw = rbc_pkg::RawW'(shadow_cfg.base_delay);
			end else begin
				prod = ProdW'(seq_raw) * ProdW'(shadow_cfg.backoff_multiplier);
				prod = prod >> 4;
				seq_raw = (prod[ProdW-1:rbc_pkg::RawW] != '0) ? '1 : prod[rbc_pkg::RawW-1:0];
			end
			d = (seq_raw > rbc_pkg::RawW'(shadow_cfg.delay_cap)) ?
				rbc_pkg::RawW'(shadow_cfg.delay_cap) : seq_raw;
			log_event(rbc_pkg::EV_RETRYING, seq_attempt, d[rbc_pkg::DelayW-1:0]);
			seq_phase  = SEQ_WAIT;
			seq_wait   = d[rbc_pkg::DelayW-1:0];
			seq_flight = '0;
		end
	endtask

	task automatic advance_sequencer(input logic [1:0] op, input logic ok,
			input logic [rbc_pkg::DelayW-1:0] tmo);
		rbc_pkg::result_t r;
		staged.delete();
		case (op)
			rbc_pkg::OP_START: begin
				clear_sequence();
				seq_timeout = tmo;
				seq_attempt = 8'd1;
				seq_phase   = SEQ_FLIGHT;
				log_event(rbc_pkg::EV_LAUNCH, 8'd1, '0);
			end
			rbc_pkg::OP_OUTCOME: begin
				if (seq_phase == SEQ_FLIGHT) begin
					if (ok) begin
						log_event(rbc_pkg::EV_SUCCEEDED, seq_attempt, '0);
						clear_sequence();
					end else begin
						note_failure();
					end
				end
			end
			rbc_pkg::OP_TICK: begin
				if (seq_phase == SEQ_FLIGHT) begin
					if (seq_timeout != '0) begin
						seq_flight = seq_flight + rbc_pkg::DelayW'(1);
						if (seq_flight >= seq_timeout) begin
							log_event(rbc_pkg::EV_TIMED_OUT, seq_attempt, seq_timeout);
							note_failure();
						end
					end
				end else if (seq_phase == SEQ_WAIT) begin
					if (seq_wait <= 20'd1) begin
						seq_wait    = '0;
						seq_attempt = seq_attempt + rbc_pkg::AttW'(1);
						seq_flight  = '0;
						seq_phase   = SEQ_FLIGHT;
						log_event(rbc_pkg::EV_LAUNCH, seq_attempt, '0);
					end else begin
						seq_wait = seq_wait - rbc_pkg::DelayW'(1);
					end
				end
			end
			default: begin
				clear_sequence();
			end
		endcase
		if (staged.size() != 0) begin
			r = staged.pop_back();
			r.last = 1'b1;
			staged.push_back(r);
		end
		foreach (staged[i]) events_due.push_back(staged[i]);
	endtask

	// driver: hold the beat until accepted, then advance to the next queued one
	always @(posedge clk) begin
		beat_t nb;
		if (arst_n) begin
			if (in_valid && in_ready)
				advance_sequencer(operation, success, timeout_ticks);
			if (!in_valid || in_ready) begin
				if (beats_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					nb = beats_to_send.pop_front();
					in_valid      <= 1'b1;
					operation     <= nb.op;
					success       <= nb.ok;
					timeout_ticks <= nb.tmo;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rbc_pkg::result_t got;
		rbc_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{event_res, attempt_number, delay_value, last};
				if (events_due.size() == 0) begin
					$display("%0t: unexpected beat event %0d attempt %0d delay %0d last %0b",
						$time, event_res, attempt_number, delay_value, last);
					errors++;
				end else begin
					want = events_due.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected event %0d attempt %0d delay %0d last %0b",
							$time, want.event_res, want.attempt_number, want.delay_value,
							want.last);
						$display("%0t:          actual   event %0d attempt %0d delay %0d last %0b",
							$time, event_res, attempt_number, delay_value, last);
						errors++;
					end
				end
			end
			out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (rx_hold_left != 0)
			rx_hold_left <= rx_hold_left - 1;
		else if (rx_hold_req)
			rx_hold_left <= 400;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("retry_backoff_controller regression: fail");
			$finish;
		end
	end

	task automatic queue_beat(input logic [1:0] op, input logic ok,
			input logic [rbc_pkg::DelayW-1:0] tmo);
		beat_t b;
		b.op  = op;
		b.ok  = ok;
		b.tmo = tmo;
		beats_to_send.push_back(b);
	endtask

	task automatic queue_random(input int count);
		beat_t       b;
		int unsigned r;
		int unsigned s;
		repeat (count) begin
			r     = $urandom_range(99);
			b.ok  = 1'($urandom_range(1));
			b.tmo = rbc_pkg::DelayW'($urandom);
			if (r < 6) begin
				b.op = rbc_pkg::OP_START;
				s = $urandom_range(9);
				if (s < 5)
					b.tmo = '0;
				else if (s < 9)
					b.tmo = rbc_pkg::DelayW'($urandom_range(6, 1));
			end else if (r < 9) begin
				b.op = rbc_pkg::OP_CANCEL;
			end else if (r < 34) begin
				b.op = rbc_pkg::OP_OUTCOME;
				b.ok = ($urandom_range(99) < 25);
			end else begin
				b.op = rbc_pkg::OP_TICK;
			end
			beats_to_send.push_back(b);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || events_due.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [rbc_pkg::AttW-1:0] lim,
			input logic [rbc_pkg::BaseW-1:0] base, input logic [rbc_pkg::MultW-1:0] mult,
			input logic [rbc_pkg::DelayW-1:0] cap);
		wait_drained();
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= rbc_pkg::REG_ATTEMPT_LIMIT;
		cfg_data  <= rbc_pkg::CfgW'(lim);
		shadow_cfg.attempt_limit = lim;
		@(posedge clk);
		cfg_index <= rbc_pkg::REG_BASE_DELAY;
		cfg_data  <= rbc_pkg::CfgW'(base);
		shadow_cfg.base_delay = base;
		@(posedge clk);
		cfg_index <= rbc_pkg::REG_MULTIPLIER;
		cfg_data  <= rbc_pkg::CfgW'(mult);
		shadow_cfg.backoff_multiplier = mult;
		@(posedge clk);
		cfg_index <= rbc_pkg::REG_DELAY_CAP;
		cfg_data  <= rbc_pkg::CfgW'(cap);
		shadow_cfg.delay_cap = cap;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic start_phase(input int unsigned tx, input int unsigned rx, input int count);
		@(negedge clk);
		tx_idle_pct  = tx;
		rx_stall_pct = rx;
		queue_random(count);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: idle noise, restart while busy, timeout, success
		@(negedge clk);
		queue_beat(rbc_pkg::OP_TICK, 1'b1, 20'hFFFFF);
		queue_beat(rbc_pkg::OP_OUTCOME, 1'b1, '0);
		queue_beat(rbc_pkg::OP_CANCEL, 1'b0, '0);
		queue_beat(rbc_pkg::OP_START, 1'b0, '0);
		queue_beat(rbc_pkg::OP_TICK, 1'b0, '0);
		queue_beat(rbc_pkg::OP_OUTCOME, 1'b0, '0);
		queue_beat(rbc_pkg::OP_OUTCOME, 1'b1, '0);
		queue_beat(rbc_pkg::OP_START, 1'b1, 20'd1);
		queue_beat(rbc_pkg::OP_TICK, 1'b0, '0);
		queue_beat(rbc_pkg::OP_CANCEL, 1'b1, 20'hFFFFF);
		queue_beat(rbc_pkg::OP_START, 1'b0, 20'hFFFFF);
		queue_beat(rbc_pkg::OP_OUTCOME, 1'b1, 20'hFFFFF);

		// zero attempt limit: first failure ends the sequence
		apply_setting(8'd0, 16'd0, 8'd0, 20'd0);
		@(negedge clk);
		queue_beat(rbc_pkg::OP_START, 1'b1, 20'd2);
		queue_beat(rbc_pkg::OP_TICK, 1'b0, '0);
		queue_beat(rbc_pkg::OP_TICK, 1'b1, '0);
		queue_beat(rbc_pkg::OP_START, 1'b0, '0);
		queue_beat(rbc_pkg::OP_OUTCOME, 1'b0, '0);

		// zero cap: retries launch on the next tick while the raw delay grows past the cap
		apply_setting(8'd255, 16'hFFFF, 8'd255, 20'd0);
		@(negedge clk);
		queue_beat(rbc_pkg::OP_START, 1'b0, '0);
		queue_beat(rbc_pkg::OP_OUTCOME, 1'b0, '0);
		queue_beat(rbc_pkg::OP_TICK, 1'b0, '0);
		queue_beat(rbc_pkg::OP_OUTCOME, 1'b0, '0);
		queue_beat(rbc_pkg::OP_TICK, 1'b1, '0);
		queue_beat(rbc_pkg::OP_CANCEL, 1'b0, '0);

		apply_setting(8'd3, 16'd2, 8'd32, 20'd12);
		start_phase(0, 0, 300);

		apply_setting(8'd6, 16'd1, 8'd24, 20'd9);
		start_phase(54, 0, 250);

		apply_setting(8'd255, 16'hFFFF, 8'd255, 20'd4);
		start_phase(0, 54, 250);
		rx_hold_req = 1'b1;
		wait (rx_hold_left != 0);
		@(negedge clk);
		rx_hold_req = 1'b0;

		apply_setting(8'd1, 16'd0, 8'd8, 20'hFFFFF);
		start_phase(32, 32, 150);

		apply_setting(8'd5, 16'd7, 8'd10, 20'hFFFFF);
		start_phase(32, 32, 200);

		wait_drained();
		@(negedge clk);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		wait_drained();
		if (errors == 0)
			$display("retry_backoff_controller regression: pass");
		else
			$display("retry_backoff_controller regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

@@ retry_backoff_controller.f @@
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_delay.sv
hw/rtl/rbc_outq.sv
hw/rtl/rbc_core.sv
hw/rtl/retry_backoff_controller.sv
dv/tb_retry_backoff_controller.sv
